@@ hdl/sibs_pkg.sv @@
package sibs_pkg;

  localparam int OUT_ADDR_W  = 24;
  localparam int CFG_INDEX_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANK   = CFG_INDEX_W'(1);

  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;
  localparam logic [7:0]  BLANK_RESET   = 8'hFF;
  localparam logic [15:0] MIN_LEN       = 16'd2;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_image;
    logic       is_blank;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic                  kind;
    logic [OUT_ADDR_W-1:0] address;
    logic [7:0]            data_byte;
    logic [15:0]           block_length;
    logic [15:0]           crc;
    logic                  last;
  } result_t;

  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_KEEP_PEND,
    ACT_KEEP_HEAD,
    ACT_BLANK,
    ACT_CUT_SUM,
    ACT_END_SUM
  } action_t;

endpackage

@@ hdl/sparse_image_block_splitter_crc16_core.sv @@
// Sparse image block splitter with CRC-16/ARC.
// Input channel (in_valid / in_stall): one image byte per word, in address
// order; in_end_of_image marks the last byte, and the next word starts a new
// image at address 0. Result channel (out_valid / out_stall): data words carry
// a kept byte and its address; summary words carry block start, length and CRC.
// out_last flags the final result caused by an input word.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 max block
// length, index 1 blank byte value. Write only while the block is idle.
// An accepted word is written into the queue, and the back-end sequencer
// registers each of its results in the output register. While out_stall is
// low, the single result port of the back end gives one result per cycle.
// A non-blank byte that ends a held run of up to BLANK_RUN-1 blank bytes
// first releases each held byte as a data word, then gives its own; a cut or
// image end adds a summary word.
// A four-word queue parts the front from the back: while the receiver stalls,
// the output register holds, the queue fills and then in_stall rises.
// Reset: queue empty, address 0, no open block, max length 1024, blank 0xFF.
module sparse_image_block_splitter_crc16_core
  import sibs_pkg::*;
#(
  parameter int BLANK_RUN  = 8,
  parameter int ADDR_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte_value,
  input  logic                   in_end_of_image,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_kind,
  output logic [OUT_ADDR_W-1:0]  out_address,
  output logic [7:0]             out_data_byte,
  output logic [15:0]            out_block_length,
  output logic [15:0]            out_crc,
  output logic                   out_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  logic [15:0] max_len_r;
  logic [7:0]  blank_r;
  push_t       push;
  logic        q_full;
  logic        q_head_valid;
  entry_t      q_head;
  logic        q_pop;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      blank_r   <= BLANK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_LEN) begin
        max_len_r <= cfg_data;
      end else if (cfg_index == CFG_BLANK) begin
        blank_r <= cfg_data[7:0];
      end
    end
  end

  sibs_front u_front (
    .in_valid        (in_valid),
    .in_byte_value   (in_byte_value),
    .in_end_of_image (in_end_of_image),
    .blank_value     (blank_r),
    .queue_full      (q_full),
    .in_stall        (in_stall),
    .push            (push)
  );

  sibs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  sibs_back #(
    .BLANK_RUN  (BLANK_RUN),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_len     (max_len_r),
    .blank_value (blank_r),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_res     (res)
  );

  assign out_kind         = res.kind;
  assign out_address      = res.address;
  assign out_data_byte    = res.data_byte;
  assign out_block_length = res.block_length;
  assign out_crc          = res.crc;
  assign out_last         = res.last;

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_DATA)) |-> (out_block_length == 16'd0 && out_crc == 16'd0))
    else $error("data word carries summary fields");

  a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_SUMMARY)) |-> (out_block_length != 16'd0
                                                   && out_data_byte == 8'd0))
    else $error("summary word with empty block or data byte");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_head_valid)
    else $error("accepted word missing from queue");

endmodule

@@ hdl/sibs_front.sv @@
module sibs_front
  import sibs_pkg::*;
(
  input  logic       in_valid,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_image,
  input  logic [7:0] blank_value,
  input  logic       queue_full,
  output logic       in_stall,
  output push_t      push
);

  // classify each word as blank or not on the way into the queue
  assign in_stall               = queue_full;
  assign push.valid             = in_valid && !queue_full;
  assign push.entry.byte_value  = in_byte_value;
  assign push.entry.end_of_image = in_end_of_image;
  assign push.entry.is_blank    = (in_byte_value == blank_value);

endmodule

@@ hdl/sibs_queue.sv @@
module sibs_queue
  import sibs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic [QPTR_W:0]     count_nxt;

  assign full       = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (!push.valid && pop) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

@@ hdl/sibs_back.sv @@
module sibs_back
  import sibs_pkg::*;
#(
  parameter int BLANK_RUN  = 8,
  parameter int ADDR_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] max_len,
  input  logic [7:0]  blank_value,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output result_t     out_res
);

  localparam int PEND_W = $clog2(BLANK_RUN);
  localparam logic [PEND_W-1:0] PEND_TOP = PEND_W'(BLANK_RUN - 1);

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // pending bytes: a run of equal bytes held back while the cut is undecided
  logic [PEND_W-1:0]     pend_r, pend_nxt;
  logic [7:0]            pend_val_r, pend_val_nxt;
  logic                  in_block_r, in_block_nxt;
  logic [ADDR_WIDTH-1:0] pos_r, pos_nxt;
  logic [ADDR_WIDTH-1:0] start_r, start_nxt;
  logic [15:0]           cnt_r, cnt_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic                  sum_pend_r, sum_pend_nxt;
  logic                  head_done_r, head_done_nxt;
  logic                  out_valid_r;
  result_t               out_r;

  action_t     act;
  logic [15:0] lim;
  logic        pend_blank;
  logic [7:0]  keep_val;
  logic [15:0] keep_cnt;
  logic [15:0] keep_crc;
  logic        can_load;
  logic        emit;
  logic        rem;
  logic        finish;
  logic        go;
  result_t     res;

  assign lim        = (max_len < MIN_LEN) ? MIN_LEN : max_len;
  assign pend_blank = (pend_val_r == blank_value);
  assign can_load   = !out_valid_r || !out_stall;

  always_comb begin
    if (!head_valid) begin
      act = ACT_IDLE;
    end else if (sum_pend_r) begin
      act = ACT_CUT_SUM;
    end else if (!head_done_r) begin
      if ((pend_r != '0) && (!pend_blank || !head.is_blank)) begin
        act = ACT_KEEP_PEND;
      end else if (!head.is_blank) begin
        act = ACT_KEEP_HEAD;
      end else begin
        act = ACT_BLANK;
      end
    end else begin
      act = ACT_END_SUM;
    end
  end

  assign keep_val = (act == ACT_KEEP_PEND) ? pend_val_r : head.byte_value;
  assign keep_cnt = in_block_r ? (cnt_r + 16'd1) : 16'd1;
  assign keep_crc = crc_byte(in_block_r ? crc_r : 16'h0000, keep_val);

  always_comb begin
    pend_nxt      = pend_r;
    pend_val_nxt  = pend_val_r;
    in_block_nxt  = in_block_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    sum_pend_nxt  = sum_pend_r;
    head_done_nxt = head_done_r;
    emit          = 1'b0;
    res           = '0;

    case (act)
      ACT_KEEP_PEND, ACT_KEEP_HEAD: begin
        emit           = 1'b1;
        res.kind       = KIND_DATA;
        res.address    = OUT_ADDR_W'(pos_r);
        res.data_byte  = keep_val;
        in_block_nxt   = 1'b1;
        start_nxt      = in_block_r ? start_r : pos_r;
        cnt_nxt        = keep_cnt;
        crc_nxt        = keep_crc;
        pos_nxt        = pos_r + ADDR_WIDTH'(1);
        sum_pend_nxt   = (keep_cnt >= lim);
        if (act == ACT_KEEP_PEND) begin
          pend_nxt = pend_r - PEND_W'(1);
        end else begin
          head_done_nxt = 1'b1;
        end
      end
      ACT_CUT_SUM: begin
        emit             = 1'b1;
        res.kind         = KIND_SUMMARY;
        res.address      = OUT_ADDR_W'(start_r);
        res.block_length = cnt_r;
        res.crc          = crc_r;
        in_block_nxt     = 1'b0;
        sum_pend_nxt     = 1'b0;
        // blank bytes held back are dropped once the block is cut
        if (pend_blank) begin
          pos_nxt  = pos_r + ADDR_WIDTH'(pend_r);
          pend_nxt = '0;
        end
      end
      ACT_BLANK: begin
        head_done_nxt = 1'b1;
        if (in_block_r && (pend_r == PEND_TOP)) begin
          emit             = 1'b1;
          res.kind         = KIND_SUMMARY;
          res.address      = OUT_ADDR_W'(start_r);
          res.block_length = cnt_r;
          res.crc          = crc_r;
          in_block_nxt     = 1'b0;
          pos_nxt          = pos_r + ADDR_WIDTH'(pend_r) + ADDR_WIDTH'(1);
          pend_nxt         = '0;
        end else if (in_block_r) begin
          pend_nxt     = pend_r + PEND_W'(1);
          pend_val_nxt = head.byte_value;
        end else begin
          pos_nxt = pos_r + ADDR_WIDTH'(1);
        end
      end
      ACT_END_SUM: begin
        emit             = 1'b1;
        res.kind         = KIND_SUMMARY;
        res.address      = OUT_ADDR_W'(start_r);
        res.block_length = cnt_r;
        res.crc          = crc_r;
        in_block_nxt     = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    // anything left for this word after the current action
    rem = sum_pend_nxt
       || ((pend_nxt != '0) && (pend_val_nxt != blank_value))
       || (!head_done_nxt && !head.is_blank)
       || (!head_done_nxt && in_block_nxt && (pend_nxt == PEND_TOP))
       || (head.end_of_image && in_block_nxt);
    res.last = !rem;

    finish = head_valid && head_done_nxt && !sum_pend_nxt
          && !(head.end_of_image && in_block_nxt);
    go     = head_valid && (!emit || can_load);
    pop    = go && finish;

    // drop the word; image end restarts addressing
    if (pop) begin
      head_done_nxt = 1'b0;
      if (head.end_of_image) begin
        pos_nxt      = '0;
        pend_nxt     = '0;
        in_block_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      in_block_r  <= 1'b0;
      pos_r       <= '0;
      sum_pend_r  <= 1'b0;
      head_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        pend_r      <= pend_nxt;
        in_block_r  <= in_block_nxt;
        pos_r       <= pos_nxt;
        sum_pend_r  <= sum_pend_nxt;
        head_done_r <= head_done_nxt;
      end
      if (can_load) begin
        out_valid_r <= go && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pend_val_r <= pend_val_nxt;
      start_r    <= start_nxt;
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
    end
    if (can_load && go && emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
